>>> hw/rtl/letter_deque_core_defines.svh
// Assertion macros shared by the letter deque RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef LETTER_DEQUE_CORE_DEFINES_SVH
`define LETTER_DEQUE_CORE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define LDQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LDQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ldq_pkg.sv
// Shared types, constants and helpers for the letter deque.
// No dependencies; used by ldq_store, letter_deque_core and tb.
package ldq_pkg;

	localparam int DEPTH   = 16;
	localparam int CHAR_W  = 8;
	localparam int ENTRY_W = 5;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;

	typedef logic [CHAR_W-1:0] byte_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SUM_W-1:0]  sum_t;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_NOT_LETTER = 2'd1,
		ST_FULL       = 2'd2,
		ST_EMPTY      = 2'd3
	} status_t;

	// One write port and one read port of the ring store.
	typedef struct packed {
		logic  we;
		ptr_t  waddr;
		byte_t wdata;
		logic  re;
		ptr_t  raddr;
	} mem_req_t;

	localparam byte_t UPPER_A = 8'h41;
	localparam byte_t UPPER_Z = 8'h5A;
	localparam byte_t LOWER_A = 8'h61;
	localparam byte_t LOWER_Z = 8'h7A;
	localparam byte_t NUL     = 8'h00;

	function automatic logic is_letter(input byte_t b);
		return ((b >= UPPER_A) && (b <= UPPER_Z)) || ((b >= LOWER_A) && (b <= LOWER_Z));
	endfunction

endpackage

>>> hw/rtl/ldq_store.sv
// Ring store of the letter deque: one write port, one read port, registered read.
// Depends on ldq_pkg.
module ldq_store (
	input  logic              clk,
	input  ldq_pkg::mem_req_t req,
	output ldq_pkg::byte_t    rdata
);

	ldq_pkg::byte_t mem_q [ldq_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Hold the read word until the next read.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end

endmodule

>>> hw/rtl/letter_deque_core.sv
// letter_deque_core: double-ended queue of ASCII letters in a ring store of DEPTH bytes.
// A word waits in the input stage, then its result in the result register; out_ready low holds both.
// Throughput: one word per cycle while out_ready is high; pointer/count update and at most one store access each.
// Reset (arst_n low, asynchronous): pointer, count, valids and read selects clear;
// the store contents stay undefined and are never read before being written.
`include "letter_deque_core_defines.svh"

module letter_deque_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] front_char,
	output logic [7:0] back_char,
	output logic       is_empty,
	output logic       is_full,
	output logic [4:0] entry_count,
	output logic [1:0] status
);

	// Input stage: one operation word waiting to be applied.
	logic                s1_v;
	ldq_pkg::cmd_t       cmd_s1;
	ldq_pkg::byte_t      ch_s1;

	// Architectural state.
	ldq_pkg::ptr_t       fp_q;
	ldq_pkg::cnt_t       cnt_q;

	// Result register. front/back either sit in front_q/back_q or, right after a pop
	// that exposed a new end, in the store's read register (select bit set).
	logic                out_v_q;
	ldq_pkg::byte_t      front_q;
	ldq_pkg::byte_t      back_q;
	logic                fsel_q;
	logic                bsel_q;
	logic                empty_q;
	logic                full_q;
	logic [ldq_pkg::ENTRY_W-1:0] count_q;
	ldq_pkg::status_t    status_q;

	ldq_pkg::byte_t      rdata;
	ldq_pkg::mem_req_t   req;

	logic                adv;
	logic                empty;
	logic                full;
	logic                last;
	ldq_pkg::byte_t      old_front;
	ldq_pkg::byte_t      old_back;
	ldq_pkg::ptr_t       fp_dec;
	ldq_pkg::ptr_t       fp_inc;
	ldq_pkg::sum_t       tail_sum;
	ldq_pkg::sum_t       tail_wrap;
	ldq_pkg::sum_t       back2_sum;
	ldq_pkg::sum_t       back2_wrap;

	ldq_pkg::ptr_t       fp_n;
	ldq_pkg::cnt_t       cnt_n;
	ldq_pkg::byte_t      front_n;
	ldq_pkg::byte_t      back_n;
	logic                fsel_n;
	logic                bsel_n;
	ldq_pkg::status_t    status_n;

	// Advance the input stage whenever the result register is free or being drained.
	assign adv      = s1_v && (!out_v_q || out_ready);
	assign in_ready = !s1_v || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_ready) begin
			s1_v <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= ldq_pkg::cmd_t'(cmd);
			ch_s1  <= ch;
		end
	end

	// Pointer arithmetic. Wrap is one compare and subtract, so DEPTH need not be a power of two.
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == ldq_pkg::CNT_W'(ldq_pkg::DEPTH));
	assign last  = (cnt_q == ldq_pkg::CNT_W'(1));

	assign fp_dec = (fp_q == '0) ? ldq_pkg::PTR_W'(ldq_pkg::DEPTH - 1) : fp_q - ldq_pkg::PTR_W'(1);
	assign fp_inc = (fp_q == ldq_pkg::PTR_W'(ldq_pkg::DEPTH - 1)) ? '0 : fp_q + ldq_pkg::PTR_W'(1);

	// Slot just past the back: free slot for a push at the back.
	assign tail_sum  = ldq_pkg::SUM_W'(fp_q) + ldq_pkg::SUM_W'(cnt_q);
	assign tail_wrap = (tail_sum >= ldq_pkg::SUM_W'(ldq_pkg::DEPTH)) ?
		tail_sum - ldq_pkg::SUM_W'(ldq_pkg::DEPTH) : tail_sum;

	// Slot before the back: the new back after a pop at the back (used with two or more entries).
	assign back2_sum  = tail_sum - ldq_pkg::SUM_W'(2);
	assign back2_wrap = (back2_sum >= ldq_pkg::SUM_W'(ldq_pkg::DEPTH)) ?
		back2_sum - ldq_pkg::SUM_W'(ldq_pkg::DEPTH) : back2_sum;

	// Current ends as last reported.
	assign old_front = fsel_q ? rdata : front_q;
	assign old_back  = bsel_q ? rdata : back_q;

	always_comb begin
		fp_n      = fp_q;
		cnt_n     = cnt_q;
		front_n   = old_front;
		back_n    = old_back;
		fsel_n    = 1'b0;
		bsel_n    = 1'b0;
		status_n  = ldq_pkg::ST_DONE;
		req.we    = 1'b0;
		req.waddr = fp_dec;
		req.wdata = ch_s1;
		req.re    = 1'b0;
		req.raddr = fp_inc;

		unique case (cmd_s1)
			ldq_pkg::CMD_PUSH_FRONT, ldq_pkg::CMD_PUSH_BACK: begin
				// Letter check ranks above the full check.
				priority if (!ldq_pkg::is_letter(ch_s1)) begin
					status_n = ldq_pkg::ST_NOT_LETTER;
				end else if (full) begin
					status_n = ldq_pkg::ST_FULL;
				end else begin
					cnt_n  = cnt_q + ldq_pkg::CNT_W'(1);
					req.we = adv;
					if (cmd_s1 == ldq_pkg::CMD_PUSH_FRONT) begin
						fp_n    = fp_dec;
						front_n = ch_s1;
						if (empty) begin
							back_n = ch_s1;
						end
					end else begin
						req.waddr = tail_wrap[ldq_pkg::PTR_W-1:0];
						back_n    = ch_s1;
						if (empty) begin
							front_n = ch_s1;
						end
					end
				end
			end
			ldq_pkg::CMD_POP_FRONT, ldq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_n = ldq_pkg::ST_EMPTY;
				end else begin
					cnt_n  = cnt_q - ldq_pkg::CNT_W'(1);
					req.re = adv && !last;
					// Fetch the newly exposed end; it lands in the read register.
					if (cmd_s1 == ldq_pkg::CMD_POP_FRONT) begin
						fp_n      = fp_inc;
						req.raddr = fp_inc;
						fsel_n    = !last;
					end else begin
						req.raddr = back2_wrap[ldq_pkg::PTR_W-1:0];
						bsel_n    = !last;
					end
				end
			end
		endcase

		// Empty queue reports zero bytes at both ends.
		if (cnt_n == '0) begin
			front_n = ldq_pkg::NUL;
			back_n  = ldq_pkg::NUL;
		end
	end

	ldq_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q    <= '0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
			fsel_q  <= 1'b0;
			bsel_q  <= 1'b0;
		end else begin
			if (adv) begin
				fp_q    <= fp_n;
				cnt_q   <= cnt_n;
				out_v_q <= 1'b1;
				fsel_q  <= fsel_n;
				bsel_q  <= bsel_n;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Result payload; hold while the consumer stalls.
	always_ff @(posedge clk) begin
		if (adv) begin
			front_q  <= front_n;
			back_q   <= back_n;
			empty_q  <= (cnt_n == '0);
			full_q   <= (cnt_n == ldq_pkg::CNT_W'(ldq_pkg::DEPTH));
			count_q  <= ldq_pkg::ENTRY_W'(cnt_n);
			status_q <= status_n;
		end
	end

	assign out_valid   = out_v_q;
	assign front_char  = old_front;
	assign back_char   = old_back;
	assign is_empty    = empty_q;
	assign is_full     = full_q;
	assign entry_count = count_q;
	assign status      = status_q;

	`LDQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= ldq_pkg::CNT_W'(ldq_pkg::DEPTH), "count above depth")
	`LDQ_ASSERT_ALWAYS(a_one_read_sel, $onehot0({fsel_q, bsel_q}), "both ends point at read register")
	`LDQ_ASSERT_SAME(a_empty_zero, out_v_q && empty_q, (front_char == ldq_pkg::NUL) && (back_char == ldq_pkg::NUL), "empty result with nonzero end byte")
	`LDQ_ASSERT_NEXT(a_reject_hold, adv && (status_n != ldq_pkg::ST_DONE), $stable(cnt_q) && $stable(fp_q), "rejected word changed state")
	`LDQ_ASSERT_SAME(a_stall_block, s1_v && !adv, !in_ready, "input taken while stage blocked")

endmodule

>>> verif/tb.sv
// Self-checking bench for letter_deque_core: directed table then phased random words.
// Needs ldq_pkg (hw/rtl/ldq_pkg.sv) and the core RTL; nothing else.
`timescale 1ns / 1ps

module tb;

	// Expected content of one result word, one member per result output port.
	typedef struct packed {
		ldq_pkg::byte_t   front_char;
		ldq_pkg::byte_t   back_char;
		logic             is_empty;
		logic             is_full;
		logic [4:0]       entry_count;
		ldq_pkg::status_t status;
	} deque_result_t;

	// One row of the directed table; known rows carry a typed-in result.
	typedef struct {
		ldq_pkg::cmd_t  op;
		ldq_pkg::byte_t data;
		bit             known;
		deque_result_t  res;
	} stim_row_t;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIX} mix_t;

	localparam int RAND_WORDS = 600;
	localparam int PHASE_LEN  = 40;
	localparam int MAX_PRINT  = 50;

	localparam deque_result_t R_NONE      = '0;
	localparam deque_result_t R_EMPTY_POP = '{ldq_pkg::NUL, ldq_pkg::NUL, 1'b1, 1'b0, 5'd0,
		ldq_pkg::ST_EMPTY};
	localparam deque_result_t R_EMPTY_BAD = '{ldq_pkg::NUL, ldq_pkg::NUL, 1'b1, 1'b0, 5'd0,
		ldq_pkg::ST_NOT_LETTER};
	localparam deque_result_t R_ONLY_A    = '{8'h41, 8'h41, 1'b0, 1'b0, 5'd1, ldq_pkg::ST_DONE};

	// Directed words: empty pops, letter range edges, both wraps of the head.
	localparam int DIR_ROWS = 21;
	stim_row_t dir_tbl [DIR_ROWS] = '{
		'{ldq_pkg::CMD_POP_FRONT,  8'h00, 1'b1, R_EMPTY_POP},  // pop front on empty
		'{ldq_pkg::CMD_POP_BACK,   8'hFF, 1'b1, R_EMPTY_POP},  // pop back on empty
		'{ldq_pkg::CMD_PUSH_FRONT, 8'h00, 1'b1, R_EMPTY_BAD},  // NUL is no letter
		'{ldq_pkg::CMD_PUSH_BACK,  8'hFF, 1'b1, R_EMPTY_BAD},  // top byte value
		'{ldq_pkg::CMD_PUSH_FRONT, 8'h40, 1'b1, R_EMPTY_BAD},  // just below 'A'
		'{ldq_pkg::CMD_PUSH_BACK,  8'h5B, 1'b1, R_EMPTY_BAD},  // just above 'Z'
		'{ldq_pkg::CMD_PUSH_FRONT, 8'h60, 1'b1, R_EMPTY_BAD},  // just below 'a'
		'{ldq_pkg::CMD_PUSH_BACK,  8'h7B, 1'b1, R_EMPTY_BAD},  // just above 'z'
		'{ldq_pkg::CMD_PUSH_BACK,  8'h41, 1'b1, R_ONLY_A},     // 'A' alone
		'{ldq_pkg::CMD_PUSH_FRONT, 8'h5A, 1'b0, R_NONE},       // head wraps below zero
		'{ldq_pkg::CMD_PUSH_BACK,  8'h61, 1'b0, R_NONE},
		'{ldq_pkg::CMD_PUSH_FRONT, 8'h7A, 1'b0, R_NONE},
		'{ldq_pkg::CMD_PUSH_BACK,  8'h80, 1'b0, R_NONE},       // non-letter with content
		'{ldq_pkg::CMD_PUSH_FRONT, 8'h7F, 1'b0, R_NONE},
		'{ldq_pkg::CMD_POP_FRONT,  8'h41, 1'b0, R_NONE},
		'{ldq_pkg::CMD_POP_BACK,   8'h00, 1'b0, R_NONE},
		'{ldq_pkg::CMD_POP_FRONT,  8'hAA, 1'b0, R_NONE},
		'{ldq_pkg::CMD_POP_BACK,   8'h55, 1'b0, R_NONE},       // drains to empty
		'{ldq_pkg::CMD_POP_FRONT,  8'h00, 1'b1, R_EMPTY_POP},
		'{ldq_pkg::CMD_PUSH_FRONT, 8'h6D, 1'b0, R_NONE},
		'{ldq_pkg::CMD_POP_FRONT,  8'h00, 1'b0, R_NONE}        // head wraps past the top
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] cmd = ldq_pkg::CMD_PUSH_FRONT;
	logic [7:0] ch = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] front_char;
	logic [7:0] back_char;
	logic       is_empty;
	logic       is_full;
	logic [4:0] entry_count;
	logic [1:0] status;

	// Shadow deque state, advanced once per accepted word.
	ldq_pkg::byte_t ring_mem [ldq_pkg::DEPTH];
	int    head_idx = 0;
	int    fill_cnt = 0;

	deque_result_t pending_results [$];
	int  mismatch_cnt = 0;
	bit  send_idle = 1'b1;
	bit  recv_idle = 1'b1;

	letter_deque_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.front_char  (front_char),
		.back_char   (back_char),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.entry_count (entry_count),
		.status      (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the core hangs on either handshake.
	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINT)
			$display("%0t ERROR %s", $time, msg);
	endtask

	// Apply one operation to the shadow deque and return what the core must report.
	function automatic deque_result_t deque_apply(input ldq_pkg::cmd_t op,
			input ldq_pkg::byte_t data);
		deque_result_t r;
		logic          letter;
		letter = ((data >= ldq_pkg::UPPER_A) && (data <= ldq_pkg::UPPER_Z)) ||
			((data >= ldq_pkg::LOWER_A) && (data <= ldq_pkg::LOWER_Z));
		r.status = ldq_pkg::ST_DONE;
		case (op)
			ldq_pkg::CMD_PUSH_FRONT, ldq_pkg::CMD_PUSH_BACK: begin
				// the letter check wins over the full check
				if (!letter) begin
					r.status = ldq_pkg::ST_NOT_LETTER;
				end else if (fill_cnt >= ldq_pkg::DEPTH) begin
					r.status = ldq_pkg::ST_FULL;
				end else begin
					if (op == ldq_pkg::CMD_PUSH_FRONT) begin
						head_idx = (head_idx == 0) ? ldq_pkg::DEPTH - 1 : head_idx - 1;
						ring_mem[head_idx] = data;
					end else begin
						ring_mem[(head_idx + fill_cnt) % ldq_pkg::DEPTH] = data;
					end
					fill_cnt++;
				end
			end
			default: begin
				if (fill_cnt == 0) begin
					r.status = ldq_pkg::ST_EMPTY;
				end else begin
					if (op == ldq_pkg::CMD_POP_FRONT)
						head_idx = (head_idx + 1) % ldq_pkg::DEPTH;
					fill_cnt--;
				end
			end
		endcase
		r.front_char  = (fill_cnt != 0) ? ring_mem[head_idx] : ldq_pkg::NUL;
		r.back_char   = (fill_cnt != 0) ?
			ring_mem[(head_idx + fill_cnt - 1) % ldq_pkg::DEPTH] : ldq_pkg::NUL;
		r.is_empty    = (fill_cnt == 0);
		r.is_full     = (fill_cnt >= ldq_pkg::DEPTH);
		r.entry_count = 5'(fill_cnt);
		return r;
	endfunction

	// Present one word at a falling edge, hold it until accepted, then queue its
	// expected result. Enter and leave at a falling edge with in_valid still high;
	// the next call either drops it for a gap or replaces the payload.
	task automatic send_word(input ldq_pkg::cmd_t op, input ldq_pkg::byte_t data,
			input bit known, input deque_result_t typed);
		int            gap;
		deque_result_t r;
		gap = send_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		ch       <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = deque_apply(op, data);
		if (known)
			r = typed;
		pending_results.insert(pending_results.size(), r);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every queued result has drained.
	task automatic drain_pause();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Stimulus: reset, directed table, then random phases that push the deque
	// toward full, toward empty, or keep it mixed.
	initial begin
		mix_t           phase;
		int             push_pct;
		bit             is_pop;
		bit             coin;
		ldq_pkg::cmd_t  op;
		ldq_pkg::byte_t data;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tbl[i])
			send_word(dir_tbl[i].op, dir_tbl[i].data, dir_tbl[i].known, dir_tbl[i].res);
		drain_pause();

		for (int n = 0; n < RAND_WORDS; n++) begin
			if (n == RAND_WORDS / 2)
				drain_pause();
			if (n % PHASE_LEN == 0) begin
				phase     = mix_t'($urandom_range(0, 2));
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			case (phase)
				PH_FILL:  push_pct = 80;
				PH_DRAIN: push_pct = 20;
				default:  push_pct = 50;
			endcase
			is_pop = ($urandom_range(0, 99) >= push_pct);
			coin   = 1'($urandom_range(0, 1));
			if (is_pop)
				op = coin ? ldq_pkg::CMD_POP_FRONT : ldq_pkg::CMD_POP_BACK;
			else
				op = coin ? ldq_pkg::CMD_PUSH_FRONT : ldq_pkg::CMD_PUSH_BACK;
			// mostly letters so pushes land; the rest spans every byte value
			if ($urandom_range(0, 99) < 85)
				data = ($urandom_range(0, 1) ? ldq_pkg::UPPER_A : ldq_pkg::LOWER_A) +
					ldq_pkg::byte_t'($urandom_range(0, 25));
			else
				data = ldq_pkg::byte_t'($urandom_range(0, 255));
			send_word(op, data, 1'b0, R_NONE);
		end
		in_valid <= 1'b0;

		// Wait out the queue, then keep the clock running to catch any stray result.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result side: when recv_idle is set, drop out_ready for a random stall before taking each word.
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = recv_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Compare every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (front_char !== want.front_char)
					report_mismatch($sformatf("front_char got %0h expected %0h",
						front_char, want.front_char));
				if (back_char !== want.back_char)
					report_mismatch($sformatf("back_char got %0h expected %0h",
						back_char, want.back_char));
				if (is_empty !== want.is_empty)
					report_mismatch($sformatf("is_empty got %0b expected %0b",
						is_empty, want.is_empty));
				if (is_full !== want.is_full)
					report_mismatch($sformatf("is_full got %0b expected %0b",
						is_full, want.is_full));
				if (entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count got %0d expected %0d",
						entry_count, want.entry_count));
				if (status !== want.status)
					report_mismatch($sformatf("status got %0d expected %s",
						status, want.status.name()));
			end
		end
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ldq_pkg.sv
hw/rtl/ldq_store.sv
hw/rtl/letter_deque_core.sv
verif/tb.sv
